/* src/stl_pkg.sv */
// shared types and constants for the sorted table lookup block
// no dependencies; used by stl_ctrl, stl_datapath and sorted_table_lookup_top
package stl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_RD_PREV,
        OP_SHIFT,
        OP_PUT,
        OP_RD_MID,
        OP_NARROW
    } t_op;

    // the read at lo is a flag beside the op, it uses the default read address
    typedef struct packed {
        t_op  op;
        logic rd_lo;
        logic res_load;
        logic res_hit;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              pos_zero;
        logic              pos_one;
        logic              key_lt_rd;
        logic              rd_eq_key;
        logic              lo_lt_hi;
        logic              lo_lt_cnt;
    } t_stat;

endpackage

/* src/sorted_table_lookup_top.sv */
// sorted table lookup: load captures the item, then shifts larger entries up one per cycle
// through the single write port and writes the item into the gap; an empty table takes it directly
// lookup is a binary search of at most ceil(log2(entries + 1)) probes, then a final check at lo
// clear and full-table loads finish at dispatch; one item at a time, next start when busy drops
// result strobe lasts one cycle, the receiver cannot stall it
// synchronous active-low reset empties the table; stored words stay undefined until written
module sorted_table_lookup_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [stl_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [stl_pkg::WORD_W-1:0]   i_item_key,
    input  logic [stl_pkg::WORD_W-1:0]          i_item_value,
    output logic                                o_strobe,
    output logic [stl_pkg::STATUS_W-1:0]        o_status,
    output logic [stl_pkg::WORD_W-1:0]          o_found_value
);

    // command and status between the controller and the datapath
    stl_pkg::t_cmd  cmd;
    stl_pkg::t_stat stat;

    // controller: sequences capture, insert shift, binary search and result transfer
    stl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_status (o_status),
        .o_cmd    (cmd)
    );

    // datapath: memories, pointers, compares and the result word
    // inputs are latched only on the capture cycle, so they need not hold after start
    stl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_item_key    (i_item_key),
        .i_item_value  (i_item_value),
        .o_stat        (stat),
        .o_found_value (o_found_value)
    );

endmodule

/* src/stl_datapath.sv */
// datapath: key and value memories, insert and search pointers, result word
// depends on stl_pkg
module stl_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stl_pkg::t_cmd                     i_cmd,
    input  logic [stl_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [stl_pkg::WORD_W-1:0] i_item_key,
    input  logic [stl_pkg::WORD_W-1:0]        i_item_value,
    output stl_pkg::t_stat                    o_stat,
    output logic [stl_pkg::WORD_W-1:0]        o_found_value
);

    logic signed [stl_pkg::WORD_W-1:0] key_mem [stl_pkg::TABLE_DEPTH];
    logic [stl_pkg::WORD_W-1:0]        val_mem [stl_pkg::TABLE_DEPTH];

    logic [stl_pkg::CNT_W-1:0]         r_count;
    logic [stl_pkg::CNT_W-1:0]         r_pos;
    logic [stl_pkg::CNT_W-1:0]         r_lo;
    logic [stl_pkg::CNT_W-1:0]         r_hi;
    logic [stl_pkg::CNT_W-1:0]         r_mid;
    logic [stl_pkg::MODE_W-1:0]        r_mode;
    logic signed [stl_pkg::WORD_W-1:0] r_key;
    logic [stl_pkg::WORD_W-1:0]        r_value;
    logic signed [stl_pkg::WORD_W-1:0] r_rd_key;
    logic [stl_pkg::WORD_W-1:0]        r_rd_value;
    logic [stl_pkg::WORD_W-1:0]        r_found_value;

    logic [stl_pkg::CNT_W-1:0]         pos_m1;
    logic [stl_pkg::CNT_W-1:0]         pos_m2;
    logic [stl_pkg::CNT_W-1:0]         mid;
    logic [stl_pkg::CNT_W-1:0]         rd_addr;
    logic                              rd_en;
    logic                              wr_en;
    logic signed [stl_pkg::WORD_W-1:0] wr_key;
    logic [stl_pkg::WORD_W-1:0]        wr_value;

    always_comb begin
        pos_m1   = r_pos - stl_pkg::CNT_W'(1);
        pos_m2   = r_pos - stl_pkg::CNT_W'(2);
        mid      = r_lo + ((r_hi - r_lo) >> 1);
        rd_en    = i_cmd.rd_lo;
        rd_addr  = r_lo;
        wr_en    = 1'b0;
        wr_key   = r_key;
        wr_value = r_value;
        case (i_cmd.op)
            stl_pkg::OP_RD_PREV: begin
                rd_en   = 1'b1;
                rd_addr = pos_m1;
            end
            stl_pkg::OP_SHIFT: begin
                // move the previous entry up and fetch the one below it
                rd_en    = 1'b1;
                rd_addr  = pos_m2;
                wr_en    = 1'b1;
                wr_key   = r_rd_key;
                wr_value = r_rd_value;
            end
            stl_pkg::OP_PUT: begin
                wr_en = 1'b1;
            end
            stl_pkg::OP_RD_MID: begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            default: begin
            end
        endcase
    end

    // memories, single write and single registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[r_pos[stl_pkg::ADDR_W-1:0]] <= wr_key;
            val_mem[r_pos[stl_pkg::ADDR_W-1:0]] <= wr_value;
        end
        if (rd_en) begin
            r_rd_key   <= key_mem[rd_addr[stl_pkg::ADDR_W-1:0]];
            r_rd_value <= val_mem[rd_addr[stl_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                stl_pkg::OP_CLEAR: r_count <= '0;
                stl_pkg::OP_PUT:   r_count <= r_count + stl_pkg::CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            stl_pkg::OP_CAPTURE: begin
                r_mode  <= i_mode;
                r_key   <= i_item_key;
                r_value <= i_item_value;
                r_pos   <= r_count;
                r_lo    <= '0;
                r_hi    <= r_count;
            end
            stl_pkg::OP_SHIFT: r_pos <= pos_m1;
            stl_pkg::OP_RD_MID: r_mid <= mid;
            stl_pkg::OP_NARROW: begin
                if (r_rd_key < r_key) begin
                    r_lo <= r_mid + stl_pkg::CNT_W'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.res_load) begin
            r_found_value <= i_cmd.res_hit ? r_rd_value : '0;
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.full      = (r_count == stl_pkg::CNT_W'(stl_pkg::TABLE_DEPTH));
        o_stat.pos_zero  = (r_pos == '0);
        o_stat.pos_one   = (r_pos == stl_pkg::CNT_W'(1));
        o_stat.key_lt_rd = (r_key < r_rd_key);
        o_stat.rd_eq_key = (r_rd_key == r_key);
        o_stat.lo_lt_hi  = (r_lo < r_hi);
        o_stat.lo_lt_cnt = (r_lo < r_count);
    end

    assign o_found_value = r_found_value;

endmodule

/* src/stl_ctrl.sv */
// controller state machine for the sorted table lookup block
// depends on stl_pkg; drives stl_datapath through t_cmd, reads t_stat
module stl_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  stl_pkg::t_stat               i_stat,
    output logic                         o_busy,
    output logic                         o_strobe,
    output logic [stl_pkg::STATUS_W-1:0] o_status,
    output stl_pkg::t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_INS_PUT,
        S_SRCH,
        S_SRCH_CMP,
        S_FIN_CHK
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_strobe, n_strobe;
    logic [stl_pkg::STATUS_W-1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_status = r_status;
        o_cmd    = '{op: stl_pkg::OP_NONE, rd_lo: 1'b0, res_load: 1'b0, res_hit: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = stl_pkg::OP_CAPTURE;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.mode)
                    stl_pkg::MODE_CLEAR: begin
                        o_cmd.op       = stl_pkg::OP_CLEAR;
                        o_cmd.res_load = 1'b1;
                        n_strobe       = 1'b1;
                        n_status       = stl_pkg::ST_OK;
                        n_state        = S_IDLE;
                    end
                    stl_pkg::MODE_LOAD: begin
                        if (i_stat.full) begin
                            o_cmd.res_load = 1'b1;
                            n_strobe       = 1'b1;
                            n_status       = stl_pkg::ST_FULL;
                            n_state        = S_IDLE;
                        end else if (i_stat.pos_zero) begin
                            o_cmd.op       = stl_pkg::OP_PUT;
                            o_cmd.res_load = 1'b1;
                            n_strobe       = 1'b1;
                            n_status       = stl_pkg::ST_OK;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.op = stl_pkg::OP_RD_PREV;
                            n_state  = S_INS_CMP;
                        end
                    end
                    stl_pkg::MODE_LOOKUP: begin
                        n_state = S_SRCH;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        n_strobe       = 1'b1;
                        n_status       = stl_pkg::ST_OK;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_INS_CMP: begin
                if (i_stat.key_lt_rd) begin
                    o_cmd.op = stl_pkg::OP_SHIFT;
                    if (i_stat.pos_one) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    o_cmd.op       = stl_pkg::OP_PUT;
                    o_cmd.res_load = 1'b1;
                    n_strobe       = 1'b1;
                    n_status       = stl_pkg::ST_OK;
                    n_state        = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_cmd.op       = stl_pkg::OP_PUT;
                o_cmd.res_load = 1'b1;
                n_strobe       = 1'b1;
                n_status       = stl_pkg::ST_OK;
                n_state        = S_IDLE;
            end
            S_SRCH: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.op = stl_pkg::OP_RD_MID;
                    n_state  = S_SRCH_CMP;
                end else begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_FIN_CHK;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.op = stl_pkg::OP_NARROW;
                n_state  = S_SRCH;
            end
            S_FIN_CHK: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_hit  = i_stat.lo_lt_cnt && i_stat.rd_eq_key;
                n_strobe       = 1'b1;
                n_status       = o_cmd.res_hit ? stl_pkg::ST_OK : stl_pkg::ST_MISS;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_status <= stl_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_status <= n_status;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;

endmodule
